FILE: sv/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg: shared types and constants of the homogeneous vertex transform
// Fixed-point formats, coefficient register indexes and the identity matrix.
// ----------------------------------------------------------------------------
package hvt_pkg;

  // Field width of every coordinate on the channels.
  localparam int FIELD_W     = 32;
  // Significant bits of a coordinate or coefficient, and fraction bits.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Derived arithmetic widths.
  localparam int PROD_W = 2 * COORD_WIDTH;      // one exact product
  localparam int PAIR_W = PROD_W + 1;           // sum of two products
  localparam int SUM_W  = PROD_W + 2;           // sum of four products
  localparam int SHR_W  = SUM_W - FRAC_BITS;    // sum after the fraction shift

  // Configuration port.
  localparam int NUM_REGS    = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 4;
  localparam int HALF_W      = 32;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 4;

  typedef logic signed [COORD_WIDTH-1:0] coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [PAIR_W-1:0]      pair_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [SHR_W-1:0]       shr_t;
  typedef logic signed [FIELD_W-1:0]     field_t;

  // Register indexes, in the order of the register map.
  localparam logic [CFG_INDEX_W-1:0] REG_ROW0_COLS01 = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW0_COLS23 = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW1_COLS01 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW1_COLS23 = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW2_COLS01 = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW2_COLS23 = CFG_INDEX_W'(5);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW3_COLS01 = CFG_INDEX_W'(6);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW3_COLS23 = CFG_INDEX_W'(7);

  // One in the coefficient format, used for the identity and for w.
  localparam coef_t ONE_FIXED = coef_t'(1) <<< FRAC_BITS;

  // Largest and smallest result in the coordinate format.
  localparam coef_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coef_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

endpackage

FILE: sv/hvt_pos_if.sv
// ----------------------------------------------------------------------------
// hvt_pos_if: input position channel
// Valid/ready channel carrying one position word of three signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
interface hvt_pos_if import hvt_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t pos_x;
  field_t pos_y;
  field_t pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

FILE: sv/hvt_clip_if.sv
// ----------------------------------------------------------------------------
// hvt_clip_if: clip-space result channel
// Valid/ready channel carrying four saturated components and an overflow flag.
// ----------------------------------------------------------------------------
interface hvt_clip_if import hvt_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t clip_x;
  field_t clip_y;
  field_t clip_z;
  field_t clip_w;
  logic   overflow;

  modport source (output valid, output clip_x, output clip_y, output clip_z,
                  output clip_w, output overflow, input ready);
  modport sink   (input valid, input clip_x, input clip_y, input clip_z,
                  input clip_w, input overflow, output ready);
endinterface

FILE: sv/homogeneous_vertex_transform_core.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_core: 4x4 matrix times (x, y, z, 1)
// Four-stage pipeline forming each row's dot product in signed fixed point,
// with exact products, a floor shift and saturation of every component.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word contents
// -------   ---------  -----------------------------------------------------
// pos       in         pos_x, pos_y, pos_z (signed Q16.16)
// clip      out        clip_x, clip_y, clip_z, clip_w (saturated), overflow
// cfg_*     in         write-only coefficient registers, index 0 to 7
//
// One word is accepted per cycle unless a stall on the output backs up to the
// first stage. Its result passes through the multiplier bank, the first pair
// of adders, the final adder with the fraction shift, and the saturation
// stage, which each hold one register stage.
// The last stage is the output register. Every stage carries its own valid
// bit and loads whenever it is empty or its successor is loading, so a stall
// on the output only backs up as far as the first empty stage and no word is
// lost or repeated. Reset (synchronous) empties the pipeline and loads the
// identity matrix.
//
module homogeneous_vertex_transform_core import hvt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  hvt_pos_if.sink                pos,
  hvt_clip_if.source             clip
);

  // --------------------------------------------------------------------------
  // Coefficient registers. Each register write carries two coefficients of
  // one row: the lower column in the low half, the higher in the high half.
  // Only the low COORD_WIDTH bits of each half are kept.
  // --------------------------------------------------------------------------
  coef_t coef [NUM_ROWS][NUM_COLS];

  coef_t cfg_lo;
  coef_t cfg_hi;

  assign cfg_lo = coef_t'(cfg_data[COORD_WIDTH-1:0]);
  assign cfg_hi = coef_t'(cfg_data[HALF_W+COORD_WIDTH-1:HALF_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          coef[r][c] <= (r == c) ? ONE_FIXED : '0;
        end
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW0_COLS01: begin coef[0][0] <= cfg_lo; coef[0][1] <= cfg_hi; end
        REG_ROW0_COLS23: begin coef[0][2] <= cfg_lo; coef[0][3] <= cfg_hi; end
        REG_ROW1_COLS01: begin coef[1][0] <= cfg_lo; coef[1][1] <= cfg_hi; end
        REG_ROW1_COLS23: begin coef[1][2] <= cfg_lo; coef[1][3] <= cfg_hi; end
        REG_ROW2_COLS01: begin coef[2][0] <= cfg_lo; coef[2][1] <= cfg_hi; end
        REG_ROW2_COLS23: begin coef[2][2] <= cfg_lo; coef[2][3] <= cfg_hi; end
        REG_ROW3_COLS01: begin coef[3][0] <= cfg_lo; coef[3][1] <= cfg_hi; end
        REG_ROW3_COLS23: begin coef[3][2] <= cfg_lo; coef[3][3] <= cfg_hi; end
        default: begin
          // Indexes beyond the register map are ignored.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or when the stage
  // after it is loading; the output register loads when it is empty or its
  // word is being taken.
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || clip.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign pos.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= pos.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: twelve exact products, coefficient times x, y and z. The input
  // coordinates use their low COORD_WIDTH bits, sign-extended.
  // --------------------------------------------------------------------------
  coef_t vec [3];
  prod_t prod [NUM_ROWS][3];

  assign vec[0] = coef_t'(pos.pos_x[COORD_WIDTH-1:0]);
  assign vec[1] = coef_t'(pos.pos_y[COORD_WIDTH-1:0]);
  assign vec[2] = coef_t'(pos.pos_z[COORD_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= prod_t'(coef[r][c]) * prod_t'(vec[c]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pair sums. The w column multiplies by one, so its product is the
  // coefficient shifted up by the fraction bits.
  // --------------------------------------------------------------------------
  pair_t pair_a [NUM_ROWS];
  pair_t pair_b [NUM_ROWS];

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        pair_a[r] <= pair_t'(prod[r][0]) + pair_t'(prod[r][1]);
        pair_b[r] <= pair_t'(prod[r][2]) + (pair_t'(coef[r][3]) <<< FRAC_BITS);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: full row sum, then an arithmetic shift that floors the result.
  // --------------------------------------------------------------------------
  sum_t row_sum [NUM_ROWS];
  shr_t row_shr [NUM_ROWS];

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      row_sum[r] = sum_t'(pair_a[r]) + sum_t'(pair_b[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        row_shr[r] <= shr_t'(row_sum[r] >>> FRAC_BITS);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: saturation to the coordinate range. A row is out of range when
  // the bits above its sign position are not all copies of the sign bit.
  // Any saturated row raises the overflow flag of the word.
  // --------------------------------------------------------------------------
  coef_t row_sat [NUM_ROWS];
  logic  row_ovf [NUM_ROWS];
  logic  any_ovf;

  always_comb begin
    any_ovf = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (row_shr[r][SHR_W-1] == 1'b0 && row_shr[r][SHR_W-2:COORD_WIDTH-1] != '0) begin
        row_sat[r] = COORD_MAX;
        row_ovf[r] = 1'b1;
      end else if (row_shr[r][SHR_W-1] == 1'b1 &&
                   row_shr[r][SHR_W-2:COORD_WIDTH-1] != '1) begin
        row_sat[r] = COORD_MIN;
        row_ovf[r] = 1'b1;
      end else begin
        row_sat[r] = row_shr[r][COORD_WIDTH-1:0];
        row_ovf[r] = 1'b0;
      end
      any_ovf = any_ovf | row_ovf[r];
    end
  end

  field_t out_x, out_y, out_z, out_w;
  logic   out_ovf;

  always_ff @(posedge clk) begin
    if (en4) begin
      out_x   <= field_t'(row_sat[0]);
      out_y   <= field_t'(row_sat[1]);
      out_z   <= field_t'(row_sat[2]);
      out_w   <= field_t'(row_sat[3]);
      out_ovf <= any_ovf;
    end
  end

  assign clip.valid    = v4;
  assign clip.clip_x   = out_x;
  assign clip.clip_y   = out_y;
  assign clip.clip_z   = out_z;
  assign clip.clip_w   = out_w;
  assign clip.overflow = out_ovf;

endmodule

FILE: tb/tb_homogeneous_vertex_transform_core.sv
// ----------------------------------------------------------------------------
// tb_homogeneous_vertex_transform_core: self-checking bench for the transform
// Drives positions through the core with a small directed set of vertices and
// matrix writes, then random phases with varied matrices and flow control.
// Every clip-space word is compared with a typed result or a fixed-point model kept here.
// ----------------------------------------------------------------------------
module tb_homogeneous_vertex_transform_core;
  import hvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth given by the core's header, used for settling pauses.
  localparam int PIPE_DEPTH     = 4;
  localparam int SETTLE_CYCLES  = 3 * PIPE_DEPTH;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_COUNT    = 8;
  localparam int VERTS_PER_PHASE = 212;

  // An index beyond the register map; the core must ignore writes to it.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = CFG_INDEX_W'(NUM_REGS + 5);
  localparam int                     LAST_INDEX   = (1 << CFG_INDEX_W) - 1;

  localparam field_t F_MAX = COORD_MAX;
  localparam field_t F_MIN = COORD_MIN;
  localparam field_t F_ONE = ONE_FIXED;

  // One clip-space word as it leaves the core.
  typedef struct {
    field_t cx;
    field_t cy;
    field_t cz;
    field_t cw;
    logic   ovf;
  } clip_word_t;

  typedef enum logic {ROW_VERTEX, ROW_REG_WRITE} row_kind_t;

  // One line of the directed stimulus. A line with a typed result carries
  // its expected word; the others are checked against the model.
  typedef struct {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]    data;
    field_t                   px;
    field_t                   py;
    field_t                   pz;
    bit                       typed;
    clip_word_t               result;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  hvt_pos_if  pos_ch ();
  hvt_clip_if clip_ch ();

  homogeneous_vertex_transform_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pos       (pos_ch.sink),
    .clip      (clip_ch.source)
  );

  // The model's own copy of the coefficient registers, reset to identity.
  logic [CFG_DATA_W-1:0] matrix_regs [NUM_REGS];

  // Words that have been predicted but not yet seen on the output.
  clip_word_t pending_clip_q [$];

  int mismatch_count;
  int sender_idle_pct;
  int receiver_stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Loads the identity matrix into the model, as the core does on reset.
  function automatic void load_identity();
    matrix_regs[REG_ROW0_COLS01] = {{HALF_W{1'b0}}, HALF_W'(ONE_FIXED)};
    matrix_regs[REG_ROW0_COLS23] = '0;
    matrix_regs[REG_ROW1_COLS01] = {HALF_W'(ONE_FIXED), {HALF_W{1'b0}}};
    matrix_regs[REG_ROW1_COLS23] = '0;
    matrix_regs[REG_ROW2_COLS01] = '0;
    matrix_regs[REG_ROW2_COLS23] = {{HALF_W{1'b0}}, HALF_W'(ONE_FIXED)};
    matrix_regs[REG_ROW3_COLS01] = '0;
    matrix_regs[REG_ROW3_COLS23] = {HALF_W'(ONE_FIXED), {HALF_W{1'b0}}};
  endfunction

  // Multiplies (x, y, z, 1) by the current matrix. The four products of a
  // row are summed exactly, shifted with rounding towards minus infinity and
  // then clamped to the coordinate range.
  function automatic clip_word_t transform_vertex(field_t x, field_t y, field_t z);
    coef_t                     vec  [NUM_COLS];
    coef_t                     coef [NUM_COLS];
    field_t                    comp [NUM_ROWS];
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W+1:0]   acc;
    logic signed [SUM_W+1:0]   scaled;
    clip_word_t                word;
    logic                      ovf;
    ovf    = 1'b0;
    vec[0] = coef_t'(x[COORD_WIDTH-1:0]);
    vec[1] = coef_t'(y[COORD_WIDTH-1:0]);
    vec[2] = coef_t'(z[COORD_WIDTH-1:0]);
    vec[3] = ONE_FIXED;
    for (int r = 0; r < NUM_ROWS; r++) begin
      coef[0] = coef_t'(matrix_regs[2*r][COORD_WIDTH-1:0]);
      coef[1] = coef_t'(matrix_regs[2*r][HALF_W +: COORD_WIDTH]);
      coef[2] = coef_t'(matrix_regs[2*r+1][COORD_WIDTH-1:0]);
      coef[3] = coef_t'(matrix_regs[2*r+1][HALF_W +: COORD_WIDTH]);
      acc = '0;
      for (int c = 0; c < NUM_COLS; c++) begin
        prod = coef[c] * vec[c];
        acc  = acc + prod;
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled > COORD_MAX) begin
        comp[r] = COORD_MAX;
        ovf     = 1'b1;
      end else if (scaled < COORD_MIN) begin
        comp[r] = COORD_MIN;
        ovf     = 1'b1;
      end else begin
        comp[r] = field_t'(coef_t'(scaled[COORD_WIDTH-1:0]));
      end
    end
    word.cx  = comp[0];
    word.cy  = comp[1];
    word.cz  = comp[2];
    word.cw  = comp[3];
    word.ovf = ovf;
    return word;
  endfunction

  function automatic clip_word_t clip_of(field_t cx, field_t cy, field_t cz, field_t cw,
                                         logic ovf);
    clip_word_t word;
    word.cx  = cx;
    word.cy  = cy;
    word.cz  = cz;
    word.cw  = cw;
    word.ovf = ovf;
    return word;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] index,
                                        logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row       = '{kind: ROW_REG_WRITE, default: '0};
    row.kind  = ROW_REG_WRITE;
    row.index = index;
    row.data  = data;
    return row;
  endfunction

  function automatic stim_row_t vertex_row(field_t x, field_t y, field_t z);
    stim_row_t row;
    row       = '{kind: ROW_VERTEX, default: '0};
    row.kind  = ROW_VERTEX;
    row.px    = x;
    row.py    = y;
    row.pz    = z;
    return row;
  endfunction

  function automatic stim_row_t typed_row(field_t x, field_t y, field_t z,
                                          clip_word_t result);
    stim_row_t row;
    row        = vertex_row(x, y, z);
    row.typed  = 1'b1;
    row.result = result;
    return row;
  endfunction

  // Half of the draws are modest values so that results stay in range, with
  // the extremes and fully random words making up the rest.
  function automatic field_t rand_coord();
    case ($urandom_range(9))
      0:       return F_MAX;
      1:       return F_MIN;
      2:       return '0;
      3, 4:    return field_t'($urandom);
      default: return field_t'($urandom_range(32'h0020_0000)) - field_t'(32'h0010_0000);
    endcase
  endfunction

  function automatic field_t rand_coef();
    case ($urandom_range(11))
      0:       return F_MAX;
      1:       return F_MIN;
      2:       return '0;
      3:       return F_ONE;
      4:       return -F_ONE;
      5:       return field_t'($urandom);
      default: return field_t'($urandom_range(32'h0008_0000)) - field_t'(32'h0004_0000);
    endcase
  endfunction

  // Writes one coefficient register. The enable is left high; the next
  // falling edge that drives a vertex or another write sets it again.
  task automatic write_register(logic [CFG_INDEX_W-1:0] index,
                                logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    pos_ch.valid <= 1'b0;
    cfg_wr_en    <= 1'b1;
    cfg_index    <= index;
    cfg_data     <= data;
    @(posedge clk);
    if (index < NUM_REGS)
      matrix_regs[index] = data;
  endtask

  // Presents one vertex, with random idle cycles first, and records the word
  // it must produce once the core has taken it.
  task automatic send_vertex(field_t x, field_t y, field_t z, bit typed,
                             clip_word_t result);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      pos_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pos_ch.valid <= 1'b1;
    pos_ch.pos_x <= x;
    pos_ch.pos_y <= y;
    pos_ch.pos_z <= z;
    do
      @(posedge clk);
    while (!pos_ch.ready);
    pending_clip_q.push_back(typed ? result : transform_vertex(x, y, z));
  endtask

  // Stops the input and waits until every predicted word has come out.
  task automatic drain_pipeline();
    @(negedge clk);
    pos_ch.valid <= 1'b0;
    cfg_wr_en    <= 1'b0;
    while (pending_clip_q.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // Receiver: ready is redrawn at every falling edge from the stall rate.
  always @(negedge clk) begin
    clip_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Output check: each word taken from the core is compared with the oldest
  // prediction. Values are read at the rising edge before the core updates.
  always @(posedge clk) begin : clip_check
    clip_word_t got;
    clip_word_t want;
    if (!rst && clip_ch.valid && clip_ch.ready) begin
      got = clip_of(clip_ch.clip_x, clip_ch.clip_y, clip_ch.clip_z, clip_ch.clip_w,
                    clip_ch.overflow);
      if (pending_clip_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected word x=%h y=%h z=%h w=%h ovf=%b", $realtime,
                   got.cx, got.cy, got.cz, got.cw, got.ovf);
      end else begin
        want = pending_clip_q.pop_front();
        if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz ||
            got.cw !== want.cw || got.ovf !== want.ovf) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch, expected x=%h y=%h z=%h w=%h ovf=%b", $realtime,
                     want.cx, want.cy, want.cz, want.cw, want.ovf);
            $display("%0t:           actual   x=%h y=%h z=%h w=%h ovf=%b", $realtime,
                     got.cx, got.cy, got.cz, got.cw, got.ovf);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin : main_flow
    stim_row_t  stim_rows [$];
    stim_row_t  row;
    clip_word_t none;
    logic [CFG_DATA_W-1:0] value;

    none               = clip_of('0, '0, '0, '0, 1'b0);
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    pos_ch.valid       = 1'b0;
    pos_ch.pos_x       = '0;
    pos_ch.pos_y       = '0;
    pos_ch.pos_z       = '0;
    clip_ch.ready      = 1'b0;
    load_identity();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Results right after reset and at saturation can be read
    // straight off the matrix; the mixed cases are left to the model.
    stim_rows = '{
      // A write to an index outside the map must leave the identity intact.
      reg_row(REG_UNMAPPED, {CFG_DATA_W{1'b1}}),
      typed_row('0, '0, '0, clip_of('0, '0, '0, F_ONE, 1'b0)),
      typed_row(F_MAX, F_MIN, -1, clip_of(F_MAX, F_MIN, -1, F_ONE, 1'b0)),
      typed_row(1, -F_ONE, 32'h5A5A_A5A5,
                clip_of(1, -F_ONE, 32'h5A5A_A5A5, F_ONE, 1'b0)),
      // Largest coefficients in row 0: both signs of saturation.
      reg_row(REG_ROW0_COLS01, {F_MAX, F_MAX}),
      typed_row(F_MAX, F_MAX, '0, clip_of(F_MAX, F_MAX, '0, F_ONE, 1'b1)),
      typed_row(F_MIN, F_MIN, '0, clip_of(F_MIN, F_MIN, '0, F_ONE, 1'b1)),
      // Most negative translation in row 3 reaches the bottom without clamping.
      reg_row(REG_ROW3_COLS23, {F_MIN, F_MIN}),
      typed_row('0, '0, '0, clip_of('0, '0, '0, F_MIN, 1'b0)),
      vertex_row(F_MIN, '0, F_MIN),
      // Half a unit on x in row 2: the shift must round towards minus infinity.
      reg_row(REG_ROW2_COLS01, {32'h0000_0000, 32'h0000_8000}),
      vertex_row(-1, '0, '0),
      vertex_row(1, '0, '0),
      vertex_row(-3, 32'h0001_0000, 32'hFFFF_FFFF),
      // A full matrix with every register written.
      reg_row(REG_ROW0_COLS23, {F_MAX, F_MIN}),
      reg_row(REG_ROW1_COLS01, {32'hFFFF_0000, 32'h0002_0000}),
      reg_row(REG_ROW1_COLS23, {32'h0001_0000, 32'hFFFF_8000}),
      reg_row(REG_ROW2_COLS23, {32'h0000_0000, 32'hFFFF_FFFF}),
      reg_row(REG_ROW3_COLS01, {32'h0000_0001, 32'hFFFF_FFFF}),
      vertex_row(32'h0003_0000, 32'hFFFE_8000, 32'h0000_1234),
      vertex_row(F_MAX, F_MAX, F_MAX),
      vertex_row(F_MIN, F_MIN, F_MIN),
      vertex_row(-1, -1, -1),
      vertex_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000)
    };

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_REG_WRITE) begin
        // Coefficients only change while nothing is in flight.
        if (pending_clip_q.size() != 0)
          drain_pipeline();
        write_register(row.index, row.data);
      end else begin
        send_vertex(row.px, row.py, row.pz, row.typed, row.result);
      end
    end
    drain_pipeline();

    // Random part: each phase loads a new matrix and then streams vertices
    // under one flow-control pattern. Phase three uses only the extreme
    // coefficients, phase five goes back to the identity.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        if (phase == 3)
          value = {($urandom_range(1) ? F_MAX : F_MIN), ($urandom_range(1) ? F_MAX : F_MIN)};
        else if (phase == 5)
          value = (r == 0 || r == 5) ? CFG_DATA_W'(HALF_W'(ONE_FIXED)) :
                  (r == 2 || r == 7) ? {HALF_W'(ONE_FIXED), {HALF_W{1'b0}}} : '0;
        else
          value = {rand_coef(), rand_coef()};
        write_register(CFG_INDEX_W'(r), value);
      end
      write_register(CFG_INDEX_W'($urandom_range(LAST_INDEX, NUM_REGS)),
                     {$urandom, $urandom});

      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 54;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 54;
        end
        default: begin
          sender_idle_pct    = 11;
          receiver_stall_pct = 11;
        end
      endcase

      for (int n = 0; n < VERTS_PER_PHASE; n++)
        send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, none);

      // Let the last words out before the matrix is touched again.
      drain_pipeline();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_clip_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
